FILE: sv/first_fit_pool_allocator_unit_defines.svh
// Assertion macros for the first-fit pool allocator.
`ifndef FIRST_FIT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fpa_pkg.sv
// Shared constants, types and helpers of the first-fit pool allocator.
package fpa_pkg;

  localparam int POOL_BYTES   = 1024;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_FREE     = 64;

  localparam int ADDR_W = $clog2(POOL_BYTES);
  localparam int LEN_W  = ADDR_W + 1;
  localparam int SUM_W  = LEN_W + 1;
  localparam int IDX_W  = $clog2(MAX_FREE);
  localparam int CNT_W  = IDX_W + 1;
  localparam int TOT_W  = 16;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RESET   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_NOSPACE = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } ft_entry_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    ft_entry_t         wdata;
    logic [IDX_W-1:0]  raddr;
  } ft_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [LEN_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } hdr_req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  bump_left;
    logic [TOT_W-1:0]  grants;
    logic [TOT_W-1:0]  returns;
  } res_t;

  // Clamp a merged length to the pool size.
  function automatic logic [LEN_W-1:0] sat_len(input logic [SUM_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = (v > SUM_W'(POOL_BYTES)) ? LEN_W'(POOL_BYTES) : v[LEN_W-1:0];
    return r;
  endfunction

endpackage

FILE: sv/first_fit_pool_allocator_unit.sv
// First-fit pool allocator: top level with memories and output register.
//
// Input channel (in_valid_i / in_stall_o) carries one command word: allocate
// request_size_i bytes, release the data area at block_address_i, or reset the
// whole pool. Output channel (out_valid_o / out_stall_i) returns one result
// word per command: status, granted data address, remaining bump space and
// the grant and release totals.
// A command is worked one at a time by a sequencer over a 64-entry free table
// RAM and a 1024-entry header RAM, each read or written once per cycle.
// Allocate scans the table entry by entry and, on a fit, shifts the following
// entries down to remove the used one; release adds a header read, the merge
// and apply states and a shift of entries to close or open a slot. Zero-size,
// null-release, reset and no-op words go straight to the result.
// in_stall_o stays high until the sequencer is back at idle; a new word may
// enter while the previous result still waits in the output register.
// When the receiver stalls, the result holds in the output register, and a
// finished following result waits in the sequencer.
// Reset clears the table count, bump offset and totals at once; no clearing
// pass is needed, so a word can be taken right after reset.
`include "first_fit_pool_allocator_unit_defines.svh"
module first_fit_pool_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [fpa_pkg::ADDR_W-1:0]  request_size_i,
  input  logic [fpa_pkg::ADDR_W-1:0]  block_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [fpa_pkg::ADDR_W-1:0]  data_address_o,
  output logic [fpa_pkg::LEN_W-1:0]   bump_space_left_o,
  output logic [fpa_pkg::TOT_W-1:0]   grant_total_o,
  output logic [fpa_pkg::TOT_W-1:0]   return_total_o
);
  import fpa_pkg::*;

  logic      busy;
  logic      res_valid;
  logic      res_ready;
  res_t      res;
  res_t      out_q;
  logic      out_valid_q;
  ft_req_t   ft_req;
  ft_entry_t ft_rdata;
  hdr_req_t  hdr_req;
  logic [LEN_W-1:0] hdr_rdata;

  assign in_stall_o = busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  fpa_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .cmd_i       (cmd_i),
    .size_i      (request_size_i),
    .baddr_i     (block_address_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ft_req_o    (ft_req),
    .ft_rdata_i  (ft_rdata),
    .hdr_req_o   (hdr_req),
    .hdr_rdata_i (hdr_rdata)
  );

  fpa_ram #(
    .WIDTH ($bits(ft_entry_t)),
    .DEPTH (MAX_FREE)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (ft_req.we),
    .waddr_i (ft_req.waddr),
    .wdata_i (ft_req.wdata),
    .raddr_i (ft_req.raddr),
    .rdata_o (ft_rdata)
  );

  fpa_ram #(
    .WIDTH (LEN_W),
    .DEPTH (POOL_BYTES)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_req.we),
    .waddr_i (hdr_req.waddr),
    .wdata_i (hdr_req.wdata),
    .raddr_i (hdr_req.raddr),
    .rdata_o (hdr_rdata)
  );

  // Output valid: load on a finished result, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign data_address_o    = out_q.addr;
  assign bump_space_left_o = out_q.bump_left;
  assign grant_total_o     = out_q.grants;
  assign return_total_o    = out_q.returns;

  `FPA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")
  `FPA_ASSERT_NOW(a_fail_no_addr, out_valid_o && (status_o != STAT_OK), data_address_o == '0, "address on failure")
  `FPA_ASSERT_NOW(a_addr_above_hdr, out_valid_o && (data_address_o != '0), data_address_o >= ADDR_W'(HEADER_BYTES), "grant below header")
  `FPA_ASSERT_NOW(a_bump_in_pool, out_valid_o, bump_space_left_o <= LEN_W'(POOL_BYTES), "bump space beyond pool")

endmodule

FILE: sv/fpa_ram.sv
// Generic simple dual-port RAM with registered read.
module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/fpa_seq.sv
// Sequencer and datapath that walk the free table for one request at a time.
module fpa_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [1:0]                cmd_i,
  input  logic [fpa_pkg::ADDR_W-1:0] size_i,
  input  logic [fpa_pkg::ADDR_W-1:0] baddr_i,
  output logic                      busy_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output fpa_pkg::res_t             res_o,
  output fpa_pkg::ft_req_t          ft_req_o,
  input  fpa_pkg::ft_entry_t        ft_rdata_i,
  output fpa_pkg::hdr_req_t         hdr_req_o,
  input  logic [fpa_pkg::LEN_W-1:0] hdr_rdata_i
);
  import fpa_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_HDR      = 10'b0000000010,
    S_SCAN_RD  = 10'b0000000100,
    S_SCAN_CMP = 10'b0000001000,
    S_MERGE    = 10'b0000010000,
    S_APPLY    = 10'b0000100000,
    S_SHIFT_RD = 10'b0001000000,
    S_SHIFT_WR = 10'b0010000000,
    S_PLACE    = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic              rel_q, rel_d;
  logic [ADDR_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0] h_q, h_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  entries_q, entries_d;
  logic [LEN_W-1:0]  bump_q, bump_d;
  logic [TOT_W-1:0]  grant_q, grant_d;
  logic [TOT_W-1:0]  return_q, return_d;
  status_e           status_q, status_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  ft_entry_t         prev_q, prev_d;
  ft_entry_t         cur_q, cur_d;
  logic              has_prev_q, has_prev_d;
  logic              cur_vld_q, cur_vld_d;
  logic              mnext_q, mnext_d;
  logic              up_q, up_d;

  logic [SUM_W-1:0]  bump_need;
  logic [SUM_W-1:0]  next_end;
  logic [SUM_W-1:0]  prev_end;
  logic              merged_next;
  logic              prev_adj;
  logic [LEN_W-1:0]  len_join;
  logic [LEN_W-1:0]  prev_join;

  // Adjacency and fit arithmetic
  assign bump_need   = SUM_W'(bump_q) + SUM_W'(HEADER_BYTES) + SUM_W'(size_q);
  assign next_end    = SUM_W'(h_q) + SUM_W'(HEADER_BYTES) + SUM_W'(len_q);
  assign prev_end    = SUM_W'(prev_q.start) + SUM_W'(HEADER_BYTES) + SUM_W'(prev_q.len);
  assign merged_next = cur_vld_q && (next_end == SUM_W'(cur_q.start));
  assign prev_adj    = has_prev_q && (prev_end == SUM_W'(h_q));
  assign len_join    = sat_len(SUM_W'(len_q) + SUM_W'(HEADER_BYTES) + SUM_W'(cur_q.len));
  assign prev_join   = sat_len(SUM_W'(prev_q.len) + SUM_W'(HEADER_BYTES) + SUM_W'(len_q));

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  // Result word
  always_comb begin
    res_o.status    = status_q;
    res_o.addr      = addr_q;
    res_o.bump_left = LEN_W'(POOL_BYTES) - bump_q;
    res_o.grants    = grant_q;
    res_o.returns   = return_q;
  end

  // Next-state and memory request logic
  always_comb begin
    state_d    = state_q;
    rel_d      = rel_q;
    size_d     = size_q;
    h_d        = h_q;
    len_d      = len_q;
    idx_d      = idx_q;
    k_d        = k_q;
    entries_d  = entries_q;
    bump_d     = bump_q;
    grant_d    = grant_q;
    return_d   = return_q;
    status_d   = status_q;
    addr_d     = addr_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    has_prev_d = has_prev_q;
    cur_vld_d  = cur_vld_q;
    mnext_d    = mnext_q;
    up_d       = up_q;

    ft_req_o        = '0;
    ft_req_o.raddr  = idx_q[IDX_W-1:0];
    hdr_req_o       = '0;
    hdr_req_o.raddr = baddr_i - ADDR_W'(HEADER_BYTES);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d = STAT_OK;
          addr_d   = '0;
          size_d   = size_i;
          idx_d    = '0;
          unique case (cmd_e'(cmd_i))
            CMD_ALLOC: begin
              rel_d = 1'b0;
              if (size_i == '0) begin
                status_d = STAT_ZERO;
                state_d  = S_DONE;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            CMD_RELEASE: begin
              rel_d = 1'b1;
              if (baddr_i < ADDR_W'(HEADER_BYTES)) begin
                status_d = STAT_IGNORED;
                state_d  = S_DONE;
              end else begin
                h_d     = baddr_i - ADDR_W'(HEADER_BYTES);
                state_d = S_HDR;
              end
            end
            CMD_RESET: begin
              entries_d = '0;
              bump_d    = '0;
              grant_d   = '0;
              return_d  = '0;
              state_d   = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Latch the block length from its header
      S_HDR: begin
        len_d      = hdr_rdata_i;
        has_prev_d = 1'b0;
        state_d    = S_SCAN_RD;
      end

      // Issue a table read or end the walk
      S_SCAN_RD: begin
        if (idx_q == entries_q) begin
          if (rel_q) begin
            cur_vld_d = 1'b0;
            state_d   = S_MERGE;
          end else begin
            if (bump_need > SUM_W'(POOL_BYTES)) begin
              status_d = STAT_NOSPACE;
            end else begin
              hdr_req_o.we    = 1'b1;
              hdr_req_o.waddr = bump_q[ADDR_W-1:0];
              hdr_req_o.wdata = LEN_W'(size_q);
              addr_d          = bump_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
              bump_d          = bump_need[LEN_W-1:0];
              grant_d         = grant_q + 1'b1;
            end
            state_d = S_DONE;
          end
        end else begin
          state_d = S_SCAN_CMP;
        end
      end

      // Compare one table entry
      S_SCAN_CMP: begin
        if (!rel_q) begin
          if (ft_rdata_i.len >= LEN_W'(size_q)) begin
            hdr_req_o.we    = 1'b1;
            hdr_req_o.waddr = ft_rdata_i.start;
            hdr_req_o.wdata = ft_rdata_i.len;
            addr_d          = ft_rdata_i.start + ADDR_W'(HEADER_BYTES);
            grant_d         = grant_q + 1'b1;
            k_d             = idx_q;
            up_d            = 1'b0;
            state_d         = S_SHIFT_RD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SCAN_RD;
          end
        end else begin
          if (ft_rdata_i.start < h_q) begin
            prev_d     = ft_rdata_i;
            has_prev_d = 1'b1;
            idx_d      = idx_q + 1'b1;
            state_d    = S_SCAN_RD;
          end else begin
            cur_d     = ft_rdata_i;
            cur_vld_d = 1'b1;
            state_d   = S_MERGE;
          end
        end
      end

      // Fold in the following neighbor
      S_MERGE: begin
        mnext_d  = merged_next;
        len_d    = merged_next ? len_join : len_q;
        return_d = return_q + 1'b1;
        state_d  = S_APPLY;
      end

      // Update the table with the freed block
      S_APPLY: begin
        if (prev_adj) begin
          ft_req_o.we          = 1'b1;
          ft_req_o.waddr       = IDX_W'(idx_q - 1'b1);
          ft_req_o.wdata.start = prev_q.start;
          ft_req_o.wdata.len   = prev_join;
          if (mnext_q) begin
            k_d     = idx_q;
            up_d    = 1'b0;
            state_d = S_SHIFT_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (mnext_q) begin
          ft_req_o.we          = 1'b1;
          ft_req_o.waddr       = idx_q[IDX_W-1:0];
          ft_req_o.wdata.start = h_q;
          ft_req_o.wdata.len   = len_q;
          state_d              = S_DONE;
        end else if (entries_q < CNT_W'(MAX_FREE)) begin
          k_d     = entries_q;
          up_d    = 1'b1;
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      // Read the entry to move
      S_SHIFT_RD: begin
        if (up_q) begin
          if (k_q > idx_q) begin
            ft_req_o.raddr = IDX_W'(k_q - 1'b1);
            state_d        = S_SHIFT_WR;
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          if ((k_q + 1'b1) < entries_q) begin
            ft_req_o.raddr = IDX_W'(k_q + 1'b1);
            state_d        = S_SHIFT_WR;
          end else begin
            entries_d = entries_q - 1'b1;
            state_d   = S_DONE;
          end
        end
      end

      // Write the moved entry one place over
      S_SHIFT_WR: begin
        ft_req_o.we    = 1'b1;
        ft_req_o.waddr = k_q[IDX_W-1:0];
        ft_req_o.wdata = ft_rdata_i;
        k_d            = up_q ? (k_q - 1'b1) : (k_q + 1'b1);
        state_d        = S_SHIFT_RD;
      end

      // Insert the freed block in its slot
      S_PLACE: begin
        ft_req_o.we          = 1'b1;
        ft_req_o.waddr       = idx_q[IDX_W-1:0];
        ft_req_o.wdata.start = h_q;
        ft_req_o.wdata.len   = len_q;
        entries_d            = entries_q + 1'b1;
        state_d              = S_DONE;
      end

      // Hold the result until the output register takes it
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      entries_q <= '0;
      bump_q    <= '0;
      grant_q   <= '0;
      return_q  <= '0;
    end else begin
      state_q   <= state_d;
      entries_q <= entries_d;
      bump_q    <= bump_d;
      grant_q   <= grant_d;
      return_q  <= return_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rel_q      <= rel_d;
    size_q     <= size_d;
    h_q        <= h_d;
    len_q      <= len_d;
    idx_q      <= idx_d;
    k_q        <= k_d;
    status_q   <= status_d;
    addr_q     <= addr_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    has_prev_q <= has_prev_d;
    cur_vld_q  <= cur_vld_d;
    mnext_q    <= mnext_d;
    up_q       <= up_d;
  end

endmodule
